[sv/assert_macros.svh]
// Concurrent assertion macros used by the KeeLoq cipher top level.
// Defining SYNTH removes every assertion from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define KQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define KQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define KQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define KQ_ASSERT(lbl, clk, rst, prop)
`define KQ_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define KQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[sv/keeloq_pkg.sv]
// Shared types, constants and round functions for the KeeLoq cipher.
// No dependencies; used by the round cell and the top level.
`default_nettype none

package keeloq_pkg;

   localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;
   localparam logic [63:0] KEY_RESET = 64'hEFCDAB2143658709;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic        valid;
      logic        op;
      logic [31:0] blk;
   } round_data_type;

   function automatic logic nlf5(input logic a, input logic b, input logic c,
                                 input logic d, input logic e);
      logic [4:0] idx;
      idx = {a, b, c, d, e};
      return NLF_TABLE[idx];
   endfunction

   function automatic logic [31:0] enc_round(input logic [31:0] x, input logic kb);
      logic fb;
      fb = nlf5(x[31], x[26], x[20], x[9], x[1]) ^ x[16] ^ x[0] ^ kb;
      return {fb, x[31:1]};
   endfunction

   function automatic logic [31:0] dec_round(input logic [31:0] x, input logic kb);
      logic fb;
      fb = nlf5(x[30], x[25], x[19], x[8], x[0]) ^ x[15] ^ x[31] ^ kb;
      return {x[30:0], fb};
   endfunction

endpackage

`default_nettype wire

[sv/keeloq_block_cipher_unit.sv]
// KeeLoq block cipher as a chain of round cells, one round per cell.
// Depends on keeloq_pkg, keeloq_round_cell and assert_macros.svh.
//
//   channel   direction  ports
//   req       in         req_valid, req_ready, req_op, req_block_in
//   rsp       out        rsp_valid, rsp_ready, rsp_block_out
//   csr       in         csr_valid, csr_ready, csr_cipher_key
//
// One item enters per cycle while the chain does not stall; each item passes
// through each round cell's register in turn; the last is the output register.
// The whole chain stalls only while a result is held and not taken.
// Synchronous reset clears the valid bits of the chain and loads the default key.
`default_nettype none
`include "assert_macros.svh"

module keeloq_block_cipher_unit
   import keeloq_pkg::*;
#(
   parameter int ROUNDS = 528
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [31:0] req_block_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_block_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [63:0] csr_cipher_key
);

   logic [63:0]    key_ff;
   logic           advance;
   round_data_type head;
   round_data_type chain [ROUNDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else if (csr_valid && csr_ready) begin
         key_ff <= csr_cipher_key;
      end
   end

   assign csr_ready = 1'b1;
   assign advance   = rsp_ready || !chain[ROUNDS-1].valid;
   assign req_ready = advance;

   assign head.valid = req_valid;
   assign head.op    = req_op;
   assign head.blk   = req_block_in;

   for (genvar j = 0; j < ROUNDS; j++) begin : g_cell
      localparam logic [5:0] KEY_ENC_IDX = 6'(j % 64);
      localparam logic [5:0] KEY_DEC_IDX = 6'((ROUNDS - 1 - j) % 64);
      if (j == 0) begin : g_first
         keeloq_round_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .key_enc (key_ff[KEY_ENC_IDX]),
            .key_dec (key_ff[KEY_DEC_IDX]),
            .prev    (head),
            .stage   (chain[j])
         );
      end else begin : g_next
         keeloq_round_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .key_enc (key_ff[KEY_ENC_IDX]),
            .key_dec (key_ff[KEY_DEC_IDX]),
            .prev    (chain[j-1]),
            .stage   (chain[j])
         );
      end
   end

   assign rsp_valid     = chain[ROUNDS-1].valid;
   assign rsp_block_out = chain[ROUNDS-1].blk;

   `KQ_ASSERT_NEXT(a_accept_enters_chain, clock, reset, req_valid && req_ready, chain[0].valid)
   `KQ_ASSERT_NEXT(a_stall_holds_head, clock, reset, !advance, $stable(chain[0].valid))
   `KQ_ASSERT_IMPL(a_reset_empties_output, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

`default_nettype wire

[sv/keeloq_round_cell.sv]
// One KeeLoq round with its pipeline register, in either direction.
// Depends on keeloq_pkg for the data type and the round functions.
`default_nettype none

module keeloq_round_cell
   import keeloq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic           key_enc,
   input  wire logic           key_dec,
   input  wire round_data_type prev,
   output round_data_type      stage
);

   logic        valid_ff;
   logic        valid_in;
   logic        op_ff;
   logic [31:0] blk_ff;
   logic [31:0] blk_in;

   assign valid_in = prev.valid;
   assign blk_in   = (prev.op == OP_DECRYPT) ? dec_round(prev.blk, key_dec)
                                             : enc_round(prev.blk, key_enc);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff  <= prev.op;
         blk_ff <= blk_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.op    = op_ff;
   assign stage.blk   = blk_ff;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for keeloq_block_cipher_unit: KeeLoq encryption and
// decryption of 32-bit blocks under several keys and idling patterns.
// Depends on keeloq_pkg and the cipher RTL only.
`timescale 1ns / 100ps

module tb
   import keeloq_pkg::*;
();

   localparam int CIPHER_ROUNDS = 528;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RANDOM_ITEMS  = 225;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [31:0] req_block_in;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_block_out;
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_cipher_key;

   logic [63:0] key_model;
   logic [31:0] expected_blocks[$];
   logic [31:0] wanted_block;
   int          sender_idle_pct   = 0;
   int          receiver_stall_pct = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   keeloq_block_cipher_unit #(.ROUNDS(CIPHER_ROUNDS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_block_in   (req_block_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_block_out  (rsp_block_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_cipher_key (csr_cipher_key)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] keeloq_transform(input logic op, input logic [31:0] blk,
                                                    input logic [63:0] key);
      logic [31:0] x;
      logic [4:0]  tap;
      logic        fb;
      int          r;
      x = blk;
      if (op == OP_ENCRYPT) begin
         for (r = 0; r < CIPHER_ROUNDS; r++) begin
            tap = {x[31], x[26], x[20], x[9], x[1]};
            fb  = NLF_TABLE[tap] ^ x[16] ^ x[0] ^ key[6'(r % 64)];
            x   = {fb, x[31:1]};
         end
      end else begin
         for (r = CIPHER_ROUNDS - 1; r >= 0; r--) begin
            tap = {x[30], x[25], x[19], x[8], x[0]};
            fb  = NLF_TABLE[tap] ^ x[15] ^ x[31] ^ key[6'(r % 64)];
            x   = {x[30:0], fb};
         end
      end
      return x;
   endfunction

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            $error("block_out: expected none, actual %h", rsp_block_out);
            error_count++;
         end else begin
            wanted_block = expected_blocks.pop_front();
            if (rsp_block_out !== wanted_block) begin
               $error("block_out: expected %h, actual %h", wanted_block, rsp_block_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_block(input logic op, input logic [31:0] blk);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_block_in <= blk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_blocks.push_back(keeloq_transform(op, blk, key_model));
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_blocks.size() != 0) @(negedge clock);
   endtask

   task automatic write_cipher_key(input logic [63:0] key);
      csr_valid      <= 1'b1;
      csr_cipher_key <= key;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      key_model = key;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_key_vectors();
      logic [31:0] edge_blocks[6];
      edge_blocks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001};
      foreach (edge_blocks[k]) begin
         send_block(OP_ENCRYPT, edge_blocks[k]);
         send_block(OP_DECRYPT, edge_blocks[k]);
      end
      wait_all_results();
   endtask

   task automatic test_key_extremes();
      write_cipher_key(64'h0);
      send_block(OP_ENCRYPT, 32'h0000_0000);
      send_block(OP_DECRYPT, 32'hFFFF_FFFF);
      wait_all_results();
      write_cipher_key('1);
      send_block(OP_ENCRYPT, 32'hFFFF_FFFF);
      send_block(OP_DECRYPT, 32'h0000_0000);
      wait_all_results();
      write_cipher_key(64'h8000_0000_0000_0000);
      send_block(OP_ENCRYPT, 32'h1234_5678);
      send_block(OP_DECRYPT, 32'h8765_4321);
      wait_all_results();
      write_cipher_key(64'h5CEC_6701_B79F_D949);
      send_block(OP_ENCRYPT, 32'hF741_E2DB);
      send_block(OP_DECRYPT, 32'hE44F_4CDF);
      wait_all_results();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int count);
      logic [31:0] last_cipher;
      logic [31:0] blk;
      logic        op;
      int          pick;
      last_cipher = $urandom;
      write_cipher_key({$urandom, $urandom});
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
      repeat (count) begin
         op   = 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 8)
            blk = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         else if (op == OP_DECRYPT && pick < 35)
            blk = last_cipher;
         else
            blk = $urandom;
         if (op == OP_ENCRYPT)
            last_cipher = keeloq_transform(op, blk, key_model);
         send_block(op, blk);
      end
      wait_all_results();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= OP_ENCRYPT;
      req_block_in   <= 32'h0;
      csr_valid      <= 1'b0;
      csr_cipher_key <= 64'h0;
      key_model       = KEY_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_key_vectors();
      test_key_extremes();
      test_random_traffic(0, 0, RANDOM_ITEMS);
      test_random_traffic(83, 0, RANDOM_ITEMS);
      test_random_traffic(0, 83, RANDOM_ITEMS);
      test_random_traffic(22, 22, RANDOM_ITEMS);

      repeat (CIPHER_ROUNDS + 16) @(negedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/keeloq_pkg.sv
sv/keeloq_round_cell.sv
sv/keeloq_block_cipher_unit.sv
tb/tb.sv
